>>> hw/rtl/mlfd_pkg.sv
// shared types and constants for the magic length frame deframer
package mlfd_pkg;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned HDR_DEPTH = 4;
  localparam int unsigned FILL_W = 3;

  localparam logic [7:0] MAGIC_BYTE = 8'h7E;
  localparam logic [SIZE_W-1:0] MAX_PAYLOAD_RESET = 16'd1500;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_CHECK_ERR = 2'd2,
    KIND_OVERSIZE  = 2'd3
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   data;
    logic [7:0]   channel;
    logic         last;
  } result_t;

endpackage

>>> hw/rtl/magic_length_frame_deframer.sv
// top level of the magic length frame deframer
// Takes one received byte per cycle unless stalled and delivers at most one
// result per byte: an input register holds the byte and feeds the header
// and payload logic, whose result lands in an output register. The input side
// stalls only when both registers hold an item and the output is stalled, so
// with no output stall the block sustains one byte every cycle. A five-byte
// header (0x7E, channel, check, size low, size high) is checked and then its
// payload bytes pass through; errors resync on buffered magic bytes.
module magic_length_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_data,
  output logic [7:0]  frame_channel,
  output logic        last_of_frame
);
  import mlfd_pkg::*;

  logic       advance;
  logic       item_valid;
  logic [7:0] item_byte;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  mlfd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  mlfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .step      (item_valid && advance),
    .item_byte (item_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mlfd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign result_kind   = out_res.kind;
  assign payload_data  = out_res.data;
  assign frame_channel = out_res.channel;
  assign last_of_frame = out_res.last;

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_CHECK_ERR || result_kind == KIND_OVERSIZE)
      |-> !last_of_frame && payload_data == 8'd0)
    else $error("error item carries payload or last mark");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_EMPTY |-> last_of_frame && payload_data == 8'd0)
    else $error("empty frame item without last mark");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled with a free stage");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    item_valid && advance && res_valid |=> out_valid)
    else $error("result lost on its way to the output register");

endmodule

>>> hw/rtl/mlfd_in_stage.sv
// input register stage holding one received byte
module mlfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      item_byte <= rx_byte;
    end
  end

endmodule

>>> hw/rtl/mlfd_parser.sv
// header parse, check, resync and payload tracking for one byte per cycle when stepped
module mlfd_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_data,
  input  logic                    step,
  input  logic [7:0]              item_byte,
  output logic                    res_valid,
  output mlfd_pkg::result_t       res
);
  import mlfd_pkg::*;

  logic [SIZE_W-1:0]      size_cap;
  logic [7:0]             hdr [HDR_DEPTH];
  logic [7:0]             hdr_next [HDR_DEPTH];
  logic [FILL_W-1:0]      fill;
  logic [FILL_W-1:0]      fill_next;
  logic                   in_payload;
  logic                   in_payload_next;
  logic [LENGTH_BITS-1:0] remaining;
  logic [LENGTH_BITS-1:0] remaining_next;
  logic [7:0]             channel;
  logic [7:0]             channel_next;
  logic [SIZE_W-1:0]      size;
  logic                   check_bad;
  logic                   size_bad;

  assign size      = {item_byte, hdr[3]};
  assign check_bad = hdr[2] != (hdr[3] ^ item_byte);
  assign size_bad  = (size > size_cap) || ((32'(size) >> LENGTH_BITS) != 32'd0);

  always_comb begin
    res_valid       = 1'b0;
    res.kind        = KIND_PAYLOAD;
    res.data        = 8'd0;
    res.channel     = channel;
    res.last        = 1'b0;
    hdr_next        = hdr;
    fill_next       = fill;
    in_payload_next = in_payload;
    remaining_next  = remaining;
    channel_next    = channel;

    if (in_payload) begin
      res_valid = 1'b1;
      res.data  = item_byte;
      res.last  = remaining <= LENGTH_BITS'(1);
      if (remaining <= LENGTH_BITS'(1)) begin
        remaining_next  = '0;
        in_payload_next = 1'b0;
      end else begin
        remaining_next = remaining - LENGTH_BITS'(1);
      end
    end else if (fill == '0 && item_byte != MAGIC_BYTE) begin
      fill_next = fill;
    end else if (fill < FILL_W'(HDR_DEPTH)) begin
      hdr_next[fill[1:0]] = item_byte;
      fill_next = fill + FILL_W'(1);
    end else if (check_bad || size_bad) begin
      res_valid   = 1'b1;
      res.kind    = check_bad ? KIND_CHECK_ERR : KIND_OVERSIZE;
      res.channel = hdr[1];
      // resync on the first magic byte after the header start
      if (hdr[1] == MAGIC_BYTE) begin
        hdr_next[0] = hdr[1];
        hdr_next[1] = hdr[2];
        hdr_next[2] = hdr[3];
        hdr_next[3] = item_byte;
        fill_next   = FILL_W'(4);
      end else if (hdr[2] == MAGIC_BYTE) begin
        hdr_next[0] = hdr[2];
        hdr_next[1] = hdr[3];
        hdr_next[2] = item_byte;
        fill_next   = FILL_W'(3);
      end else if (hdr[3] == MAGIC_BYTE) begin
        hdr_next[0] = hdr[3];
        hdr_next[1] = item_byte;
        fill_next   = FILL_W'(2);
      end else if (item_byte == MAGIC_BYTE) begin
        hdr_next[0] = item_byte;
        fill_next   = FILL_W'(1);
      end else begin
        fill_next = '0;
      end
    end else begin
      fill_next = '0;
      if (size == '0) begin
        res_valid   = 1'b1;
        res.kind    = KIND_EMPTY;
        res.channel = hdr[1];
        res.last    = 1'b1;
      end else begin
        in_payload_next = 1'b1;
        remaining_next  = size[LENGTH_BITS-1:0];
        channel_next    = hdr[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cap    <= MAX_PAYLOAD_RESET;
      fill        <= '0;
      in_payload  <= 1'b0;
      remaining   <= '0;
      channel     <= 8'd0;
      for (int i = 0; i < HDR_DEPTH; i++) begin
        hdr[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        size_cap <= cfg_data;
      end
      if (step) begin
        fill       <= fill_next;
        in_payload <= in_payload_next;
        remaining  <= remaining_next;
        channel    <= channel_next;
        hdr        <= hdr_next;
      end
    end
  end

endmodule

>>> hw/rtl/mlfd_out_stage.sv
// result register toward the output channel
module mlfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              res_valid,
  input  mlfd_pkg::result_t res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output mlfd_pkg::result_t out_res
);
  import mlfd_pkg::*;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && res_valid;
    end
    if (advance && item_valid && res_valid) begin
      out_res <= res;
    end
  end

endmodule
